// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== hw/rtl/btwf_pkg.sv =====
// ----------------------------------------------------------------------------
// btwf_pkg
// Shared constants and types for the best trimmed window finder.
// ----------------------------------------------------------------------------
package btwf_pkg;
   localparam int WinMax     = 64;
   localparam int IdxBits    = 6;
   localparam int SampleBits = 16;
   localparam int LenBits    = 7;
   localparam int SumBits    = 22;
   localparam int ScoreBits  = 24;
   localparam int PosBits    = 33;
   localparam int QDepth     = 4;
   localparam int QPtrBits   = 2;

   typedef struct packed {
      logic [SampleBits-1:0] sample;
      logic                  last;
   } req_type;

   typedef struct packed {
      logic [31:0] best_start;
      logic        found;
      logic        too_long;
   } rsp_type;

   // Classified item handed from front to back.
   typedef struct packed {
      logic [SampleBits-1:0] sample;
      logic                  last;
      logic                  skip;  // position counter overran
   } work_type;

   // One deque entry: sample position and value.
   typedef struct packed {
      logic [31:0]           pos;
      logic [SampleBits-1:0] val;
   } dq_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXPIRE,
      ST_POP,
      ST_SCORE,
      ST_EMIT
   } back_state_type;
endpackage

// ===== hw/rtl/btwf_if.sv =====
// ----------------------------------------------------------------------------
// btwf_req_if / btwf_rsp_if
// Valid/ready channels for the block.
// ----------------------------------------------------------------------------
interface btwf_req_if;
   logic             valid;
   logic             ready;
   btwf_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface btwf_rsp_if;
   logic             valid;
   logic             ready;
   btwf_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/btwf_front.sv =====
// ----------------------------------------------------------------------------
// btwf_front
// Accepts samples, tracks the position counter, queues work for the back end.
// ----------------------------------------------------------------------------
module btwf_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   btwf_req_if.sink             req,
   output logic                 q_valid,
   output btwf_pkg::work_type   q_data,
   input  logic                 q_pop
);
   localparam int QPtrBits = btwf_pkg::QPtrBits;

   btwf_pkg::work_type          mem_ff [btwf_pkg::QDepth];
   logic [btwf_pkg::QPtrBits-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [btwf_pkg::QPtrBits:0]   cnt_ff, cnt_in;
   logic [btwf_pkg::PosBits-1:0]  pos_ff, pos_in;
   logic                          push;
   btwf_pkg::work_type            item;

   assign req.ready = (cnt_ff != 3'(btwf_pkg::QDepth)) && !clear;
   assign push      = req.valid && req.ready;
   assign q_valid   = cnt_ff != '0;
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      item.sample = req.data.sample;
      item.last   = req.data.last;
      item.skip   = pos_ff[btwf_pkg::PosBits-1];
      wr_in  = wr_ff + QPtrBits'(push);
      rd_in  = rd_ff + QPtrBits'(q_pop);
      cnt_in = cnt_ff + 3'(push) - 3'(q_pop);
      pos_in = pos_ff;
      if (push) begin
         if (req.data.last) begin
            pos_in = '0;
         end else if (!pos_ff[btwf_pkg::PosBits-1]) begin
            pos_in = pos_ff + 33'd1;
         end
      end
      if (clear) begin
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         pos_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= item;
      end
   end
endmodule

// ===== hw/rtl/btwf_back.sv =====
// ----------------------------------------------------------------------------
// btwf_back
// Runs the ring sum and the two monotonic deques, scores windows, emits result.
// ----------------------------------------------------------------------------
module btwf_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic [btwf_pkg::LenBits-1:0] len,
   input  logic                        q_valid,
   input  btwf_pkg::work_type          q_data,
   output logic                        q_pop,
   btwf_rsp_if.source                  rsp,
   output logic                        busy
);
   localparam int IB = btwf_pkg::IdxBits;
   localparam int SB = btwf_pkg::SampleBits;

   // Storage reads are registered. Read addresses follow the next-cycle
   // pointers, so the read registers always hold the current head and tail.
   btwf_pkg::dq_entry_type maxq_ff [btwf_pkg::WinMax];
   btwf_pkg::dq_entry_type minq_ff [btwf_pkg::WinMax];
   logic [SB-1:0]          ring_ff [btwf_pkg::WinMax];

   btwf_pkg::back_state_type st_ff, st_in;
   btwf_pkg::work_type       cur_ff;
   logic [IB-1:0]  mxh_ff, mxh_in, mnh_ff, mnh_in;
   logic [IB:0]    mxc_ff, mxc_in, mnc_ff, mnc_in;
   logic [31:0]    pos_ff, pos_in;
   logic [btwf_pkg::SumBits-1:0]   sum_ff, sum_in;
   logic signed [btwf_pkg::ScoreBits-1:0] best_ff, best_in;
   logic [31:0]    bpos_ff, bpos_in;
   logic           ovf_ff, ovf_in;
   logic           rv_ff, rv_in;
   btwf_pkg::rsp_type rd_ff, rd_in;
   btwf_pkg::dq_entry_type mxhd_ff, mxtl_ff, mnhd_ff, mntl_ff, new_ent;
   logic [SB-1:0]  ring_rd_ff;
   logic [IB:0]    elen;
   logic [IB-1:0]  mxh_ra, mxt_ra, mnh_ra, mnt_ra, mx_wa, mn_wa, ring_ra;
   logic           mx_pop, mn_pop, full;
   logic           ring_we, mx_we, mn_we;
   logic signed [btwf_pkg::ScoreBits-1:0] score;
   logic [31:0]    sub;

   always_comb begin
      if (len == '0) elen = 7'd1;
      else if (len > 7'(btwf_pkg::WinMax)) elen = 7'(btwf_pkg::WinMax);
      else elen = len;
   end

   assign new_ent = {pos_ff, cur_ff.sample};
   assign mx_wa   = mxh_ff + IB'(mxc_ff);
   assign mn_wa   = mnh_ff + IB'(mnc_ff);
   assign mxh_ra  = mxh_in;
   assign mnh_ra  = mnh_in;
   assign mxt_ra  = mxh_in + IB'(mxc_in - 7'd1);
   assign mnt_ra  = mnh_in + IB'(mnc_in - 7'd1);
   assign ring_ra = pos_in[IB-1:0] - IB'(elen);
   assign full    = pos_ff >= 32'(elen);
   assign sub     = pos_ff - 32'(elen);
   assign mx_pop  = (mxc_ff != '0) && (mxtl_ff.val <= cur_ff.sample);
   assign mn_pop  = (mnc_ff != '0) && (mntl_ff.val >= cur_ff.sample);
   assign score   = $signed({2'b00, sum_ff}) - $signed(24'(mxhd_ff.val))
                    - $signed(24'(mnhd_ff.val));
   assign q_pop   = (st_ff == btwf_pkg::ST_IDLE) && q_valid && !clear;
   assign busy    = st_ff != btwf_pkg::ST_IDLE;
   assign rsp.valid = rv_ff;
   assign rsp.data  = rd_ff;

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         btwf_pkg::ST_IDLE:   if (q_pop) st_in = btwf_pkg::ST_EXPIRE;
         btwf_pkg::ST_EXPIRE: st_in = cur_ff.skip ? btwf_pkg::ST_EMIT : btwf_pkg::ST_POP;
         btwf_pkg::ST_POP:    if (!mx_pop && !mn_pop) st_in = btwf_pkg::ST_SCORE;
         btwf_pkg::ST_SCORE:  st_in = btwf_pkg::ST_EMIT;
         btwf_pkg::ST_EMIT:   if (!cur_ff.last || !rv_ff || rsp.ready)
                                 st_in = btwf_pkg::ST_IDLE;
         default:             st_in = btwf_pkg::ST_IDLE;
      endcase
      if (clear) st_in = btwf_pkg::ST_IDLE;
   end

   always_comb begin
      mxh_in = mxh_ff; mnh_in = mnh_ff; mxc_in = mxc_ff; mnc_in = mnc_ff;
      pos_in = pos_ff; sum_in = sum_ff; best_in = best_ff; bpos_in = bpos_ff;
      ovf_in = ovf_ff; rd_in = rd_ff;
      ring_we = 1'b0; mx_we = 1'b0; mn_we = 1'b0;
      rv_in = rv_ff && !rsp.ready;
      case (st_ff)
         btwf_pkg::ST_EXPIRE: begin
            if (cur_ff.skip) begin
               ovf_in = 1'b1;
            end else begin
               // drop expired fronts, adjust the ring sum
               if (mxc_ff != '0 && full && mxhd_ff.pos <= sub) begin
                  mxh_in = mxh_ff + IB'(1); mxc_in = mxc_ff - 7'd1;
               end
               if (mnc_ff != '0 && full && mnhd_ff.pos <= sub) begin
                  mnh_in = mnh_ff + IB'(1); mnc_in = mnc_ff - 7'd1;
               end
               sum_in = sum_ff + 22'(cur_ff.sample)
                        - (full ? 22'(ring_rd_ff) : 22'd0);
               ring_we = 1'b1;
            end
         end
         btwf_pkg::ST_POP: begin
            if (mx_pop) mxc_in = mxc_ff - 7'd1;
            if (mn_pop) mnc_in = mnc_ff - 7'd1;
            if (!mx_pop && !mn_pop) begin
               mx_we = 1'b1; mn_we = 1'b1;
               mxc_in = mxc_ff + 7'd1; mnc_in = mnc_ff + 7'd1;
            end
         end
         btwf_pkg::ST_SCORE: begin
            if (pos_ff + 32'd1 >= 32'(elen) && score > best_ff) begin
               best_in = score;
               bpos_in = pos_ff - 32'(elen) + 32'd2;
            end
            pos_in = pos_ff + 32'd1;
         end
         btwf_pkg::ST_EMIT: begin
            if (cur_ff.last && (!rv_ff || rsp.ready)) begin
               rv_in = 1'b1;
               rd_in.found      = !best_ff[btwf_pkg::ScoreBits-1];
               rd_in.best_start = best_ff[btwf_pkg::ScoreBits-1] ? 32'd0 : bpos_ff;
               rd_in.too_long   = ovf_ff;
               mxh_in = '0; mnh_in = '0; mxc_in = '0; mnc_in = '0;
               pos_in = '0; sum_in = '0; best_in = '1; bpos_in = '0; ovf_in = 1'b0;
            end
         end
         default: ;
      endcase
      if (clear) begin
         mxh_in = '0; mnh_in = '0; mxc_in = '0; mnc_in = '0;
         pos_in = '0; sum_in = '0; best_in = '1; bpos_in = '0; ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= btwf_pkg::ST_IDLE;
         mxh_ff <= '0; mnh_ff <= '0; mxc_ff <= '0; mnc_ff <= '0;
         pos_ff <= '0; sum_ff <= '0; best_ff <= '1; bpos_ff <= '0;
         ovf_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         mxh_ff <= mxh_in; mnh_ff <= mnh_in; mxc_ff <= mxc_in; mnc_ff <= mnc_in;
         pos_ff <= pos_in; sum_ff <= sum_in; best_ff <= best_in; bpos_ff <= bpos_in;
         ovf_ff <= ovf_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= rd_in;
      if (q_pop) cur_ff <= q_data;
      if (ring_we) ring_ff[pos_ff[IB-1:0]] <= cur_ff.sample;
      ring_rd_ff <= ring_ff[ring_ra];
      if (mx_we) maxq_ff[mx_wa] <= new_ent;
      if (mn_we) minq_ff[mn_wa] <= new_ent;
      // a push lands where the head or tail read points next
      mxhd_ff <= (mx_we && mx_wa == mxh_ra) ? new_ent : maxq_ff[mxh_ra];
      mxtl_ff <= (mx_we && mx_wa == mxt_ra) ? new_ent : maxq_ff[mxt_ra];
      mnhd_ff <= (mn_we && mn_wa == mnh_ra) ? new_ent : minq_ff[mnh_ra];
      mntl_ff <= (mn_we && mn_wa == mnt_ra) ? new_ent : minq_ff[mnt_ra];
   end
endmodule

// ===== hw/rtl/best_trimmed_window_finder_top.sv =====
// ----------------------------------------------------------------------------
// best_trimmed_window_finder_top
// Sliding-window trimmed score search over a sample stream.
// ----------------------------------------------------------------------------
// Unskipped samples pass back-end states EXPIRE, POP, SCORE and EMIT, staying
// in POP while tails pop. Both deques pop in the same cycle, so the deque with
// more pops sets how long POP lasts. A closing sample waits in EMIT while the
// previous result is unaccepted. Pops amortize to about one per sample. A
// 4-entry queue separates input acceptance from the back-end sequencer. A
// register write clears the sequence state and restarts the window count.
`include "assert_macros.svh"
module best_trimmed_window_finder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   btwf_req_if.sink    req,
   btwf_rsp_if.source  rsp
);
   logic [btwf_pkg::LenBits-1:0] len_ff;
   logic               q_valid, q_pop, busy;
   btwf_pkg::work_type q_data;

   always_ff @(posedge clock) begin
      if (reset) len_ff <= 7'd3;
      else if (csr_we) len_ff <= csr_wdata;
   end

   btwf_front u_front (
      .clock(clock), .reset(reset), .clear(csr_we), .req(req),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
   );

   btwf_back u_back (
      .clock(clock), .reset(reset), .clear(csr_we), .len(len_ff),
      .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop), .rsp(rsp), .busy(busy)
   );

   `ASSERT_NEXT(a_pop_busy, clock, reset, q_pop, busy || csr_we)
   `ASSERT_IMPLIES(a_pop_valid, clock, reset, q_pop, q_valid)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp.valid && !rsp.ready, rsp.valid)
endmodule
